/* src/salru_pkg.sv */
// salru_pkg: shared types and codes for the size-aware lru evictor
// no dependencies
package salru_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned SizeW = 40;
  localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};
  localparam logic [SizeW-1:0] CapReset = 40'd1073741824;

  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_RESULT
  } state_e;

  // result item as held in the output register
  typedef struct packed {
    logic             kind;
    logic [KeyW-1:0]  evicted_key;
    logic [SizeW-1:0] evicted_size;
    logic             hit;
    logic             rejected;
    logic [SizeW-1:0] free_space;
    logic             last;
  } result_t;

endpackage

/* src/salru_table.sv */
// salru_table: key, size, valid and rank storage, scanned one slot a cycle
// depends on salru_pkg
module salru_table import salru_pkg::*; #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IdxW    = $clog2(ENTRIES),
  parameter int unsigned RankW   = $clog2(ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // scan read port: valid and rank at rd_idx, key and size registered from pf_idx
  input  logic [IdxW-1:0]  rd_idx_i,
  input  logic [IdxW-1:0]  pf_idx_i,
  output logic [KeyW-1:0]  rd_key_o,
  output logic [SizeW-1:0] rd_size_o,
  output logic             rd_valid_o,
  output logic [RankW-1:0] rd_rank_o,
  // slot write on store
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  input  logic [KeyW-1:0]  wr_key_i,
  input  logic [SizeW-1:0] wr_size_i,
  // rank maintenance, all slots at once
  input  logic             age_all_i,    // every valid rank + 1
  input  logic             touch_i,      // ranks below ref + 1, slot to 0
  input  logic             drop_i,       // ranks above ref - 1, slot invalid
  input  logic [IdxW-1:0]  ref_idx_i,
  input  logic [RankW-1:0] ref_rank_i,
  input  logic             clear_i
);

  logic [KeyW-1:0]  keys_q  [ENTRIES];
  logic [SizeW-1:0] sizes_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [RankW-1:0] rank_q [ENTRIES];

  // payload memory, read at the prefetch index and registered so it lines up with the scan
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      keys_q[wr_idx_i]  <= wr_key_i;
      sizes_q[wr_idx_i] <= wr_size_i;
    end
    rd_key_o  <= keys_q[pf_idx_i];
    rd_size_o <= sizes_q[pf_idx_i];
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];

  // per-slot valid and rank update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (age_all_i && valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
        if (touch_i && valid_q[i] && rank_q[i] < ref_rank_i)
          rank_q[i] <= rank_q[i] + 1'b1;
        if (drop_i && valid_q[i] && rank_q[i] > ref_rank_i)
          rank_q[i] <= rank_q[i] - 1'b1;
      end
      if (touch_i) rank_q[ref_idx_i] <= '0;
      if (drop_i) begin
        valid_q[ref_idx_i] <= 1'b0;
        rank_q[ref_idx_i]  <= '0;
      end
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
        rank_q[wr_idx_i]  <= '0;
      end
    end
  end

endmodule

/* src/salru_ctrl.sv */
// salru_ctrl: command sequencer, scan unit and free-space accounting
// depends on salru_pkg
module salru_ctrl import salru_pkg::*; #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned IdxW    = $clog2(ENTRIES),
  parameter int unsigned RankW   = $clog2(ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SizeW-1:0] capacity_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [SizeW-1:0] seg_size_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  // table side
  output logic [IdxW-1:0]  rd_idx_o,
  output logic [IdxW-1:0]  pf_idx_o,
  input  logic [KeyW-1:0]  rd_key_i,
  input  logic [SizeW-1:0] rd_size_i,
  input  logic             rd_valid_i,
  input  logic [RankW-1:0] rd_rank_i,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_idx_o,
  output logic [KeyW-1:0]  wr_key_o,
  output logic [SizeW-1:0] wr_size_o,
  output logic             age_all_o,
  output logic             touch_o,
  output logic             drop_o,
  output logic [IdxW-1:0]  ref_idx_o,
  output logic [RankW-1:0] ref_rank_o,
  output logic             clear_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0] Full    = CntW'(ENTRIES);

  state_e state_q, state_d;
  cmd_e cmd_q;
  logic [KeyW-1:0]  key_q;
  logic [SizeW-1:0] size_q;
  logic [IdxW-1:0]  idx_q;
  // scan findings
  logic             fnd_q, lru_ok_q, free_ok_q;
  logic [IdxW-1:0]  fnd_idx_q, lru_idx_q, free_idx_q;
  logic [RankW-1:0] fnd_rank_q, lru_rank_q;
  logic [SizeW-1:0] lru_size_q, fnd_size_q;
  logic [KeyW-1:0]  lru_key_q;
  logic [SizeW-1:0] free_q;
  logic [CntW-1:0]  held_q;
  // completion flags, copied into the result register when it is free
  logic             hit_q, rej_q;
  logic             res_v_q;
  result_t          res_q;

  logic [SizeW:0] give_sum;
  logic need_room;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign rd_idx_o    = idx_q;
  assign pf_idx_o    = (state_q == ST_SCAN && idx_q != LastIdx) ? idx_q + 1'b1 : '0;
  assign wr_idx_o    = free_idx_q;
  assign wr_key_o    = key_q;
  assign wr_size_o   = size_q;
  assign ref_rank_o  = (state_q == ST_EVICT) ? lru_rank_q : fnd_rank_q;
  assign ref_idx_o   = (state_q == ST_EVICT) ? lru_idx_q  : fnd_idx_q;
  assign give_sum    = {1'b0, free_q} + {1'b0, (state_q == ST_EVICT) ? lru_size_q : fnd_size_q};
  assign need_room   = (free_q < size_q) || (held_q >= Full);

  // next state and table strobes
  always_comb begin
    state_d   = state_q;
    wr_en_o   = 1'b0;
    age_all_o = 1'b0;
    touch_o   = 1'b0;
    drop_o    = 1'b0;
    clear_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_e'(command_i) == CMD_CLEAR) state_d = ST_RESULT;
          else if (cmd_e'(command_i) == CMD_STORE && seg_size_i > capacity_i)
            state_d = ST_RESULT;
          else state_d = ST_SCAN;
        end
      end
      ST_SCAN:   if (idx_q == LastIdx) state_d = ST_DECIDE;
      ST_DECIDE: begin
        case (cmd_q)
          CMD_STORE: begin
            if (need_room && lru_ok_q) state_d = ST_EVICT;
            else begin
              state_d = ST_RESULT;
              if (!need_room && free_ok_q) begin
                wr_en_o   = 1'b1;
                age_all_o = 1'b1;
              end
            end
          end
          CMD_LOAD: begin
            touch_o = fnd_q;
            state_d = ST_RESULT;
          end
          CMD_REMOVE: begin
            drop_o  = fnd_q;
            state_d = ST_RESULT;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_EVICT: if (!res_v_q) begin
        drop_o  = 1'b1;
        state_d = ST_SCAN;
      end
      ST_RESULT: if (!res_v_q) begin
        clear_o = (cmd_q == CMD_CLEAR);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // datapath: one slot examined per scan cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= CapReset;
      held_q  <= '0;
      res_v_q <= 1'b0;
      cmd_q   <= CMD_STORE;
      idx_q   <= '0;
      fnd_q <= 1'b0; lru_ok_q <= 1'b0; free_ok_q <= 1'b0;
      hit_q <= 1'b0; rej_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_valid_i) begin
          cmd_q  <= cmd_e'(command_i);
          key_q  <= key_i;
          size_q <= seg_size_i;
          idx_q  <= '0;
          fnd_q <= 1'b0; lru_ok_q <= 1'b0; free_ok_q <= 1'b0;
          hit_q <= 1'b0;
          rej_q <= (cmd_e'(command_i) == CMD_STORE && seg_size_i > capacity_i);
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (rd_valid_i && rd_key_i == key_q && !fnd_q) begin
            fnd_q <= 1'b1; fnd_idx_q <= idx_q;
            fnd_rank_q <= rd_rank_i; fnd_size_q <= rd_size_i;
          end
          if (rd_valid_i && (!lru_ok_q || rd_rank_i > lru_rank_q)) begin
            lru_ok_q <= 1'b1; lru_idx_q <= idx_q; lru_rank_q <= rd_rank_i;
            lru_key_q <= rd_key_i; lru_size_q <= rd_size_i;
          end
          if (!rd_valid_i && !free_ok_q) begin
            free_ok_q <= 1'b1; free_idx_q <= idx_q;
          end
        end
        ST_DECIDE: begin
          case (cmd_q)
            CMD_STORE: if (!(need_room && lru_ok_q)) begin
              if (!need_room && free_ok_q) begin
                free_q <= free_q - size_q;
                held_q <= held_q + 1'b1;
              end else rej_q <= 1'b1;
            end
            CMD_LOAD: hit_q <= fnd_q;
            CMD_REMOVE: begin
              hit_q <= fnd_q;
              if (fnd_q) begin
                free_q <= give_sum[SizeW] ? SizeMax : give_sum[SizeW-1:0];
                held_q <= held_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_EVICT: if (!res_v_q) begin
          res_v_q <= 1'b1;
          res_q.kind <= 1'b1; res_q.evicted_key <= lru_key_q;
          res_q.evicted_size <= lru_size_q; res_q.last <= 1'b0;
          res_q.hit <= 1'b0; res_q.rejected <= 1'b0;
          res_q.free_space <= give_sum[SizeW] ? SizeMax : give_sum[SizeW-1:0];
          free_q <= give_sum[SizeW] ? SizeMax : give_sum[SizeW-1:0];
          held_q <= held_q - 1'b1;
          idx_q  <= '0;
          fnd_q <= 1'b0; lru_ok_q <= 1'b0; free_ok_q <= 1'b0;
        end
        ST_RESULT: if (!res_v_q) begin
          res_v_q <= 1'b1;
          res_q.kind <= 1'b0; res_q.evicted_key <= '0;
          res_q.evicted_size <= '0; res_q.last <= 1'b1;
          res_q.hit <= hit_q; res_q.rejected <= rej_q;
          if (cmd_q == CMD_CLEAR) begin
            free_q <= capacity_i; held_q <= '0;
            res_q.free_space <= capacity_i;
          end else res_q.free_space <= free_q;
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/size_aware_lru_evictor_top.sv */
// channel  | signals                                   | direction
// command  | in_valid_i/in_ready_o, command/key/size   | in
// result   | out_valid_o/out_ready_i, kind..last       | out
// config   | cfg_we_i, cfg_data_i                      | in
// each command other than clear and oversize store scans all ENTRIES slots, one
// slot per cycle, and a store scans them again after each eviction; clear and
// oversize store skip the scan. the slot scan goes through the single read port.
// reset empties the table and sets free space to capacity; a stalled result
// holds the sequencer until taken.
// depends on salru_pkg, salru_table, salru_ctrl
module size_aware_lru_evictor_top import salru_pkg::*; #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [SizeW-1:0] seg_size_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [KeyW-1:0]  evicted_key_o,
  output logic [SizeW-1:0] evicted_size_o,
  output logic             hit_o,
  output logic             rejected_o,
  output logic [SizeW-1:0] free_space_o,
  output logic             last_o
);

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned RankW = $clog2(ENTRIES);

  logic [SizeW-1:0] capacity_q;
  result_t res;
  logic [IdxW-1:0]  rd_idx, pf_idx, wr_idx, ref_idx;
  logic [KeyW-1:0]  rd_key, wr_key;
  logic [SizeW-1:0] rd_size, wr_size;
  logic             rd_valid, wr_en, age_all, touch, drop, clr;
  logic [RankW-1:0] rd_rank, ref_rank;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       capacity_q <= CapReset;
    else if (cfg_we_i) capacity_q <= cfg_data_i;
  end

  salru_table #(.ENTRIES(ENTRIES), .IdxW(IdxW), .RankW(RankW)) u_table (
    .clk_i, .rst_ni,
    .rd_idx_i(rd_idx), .pf_idx_i(pf_idx), .rd_key_o(rd_key), .rd_size_o(rd_size),
    .rd_valid_o(rd_valid), .rd_rank_o(rd_rank),
    .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_key_i(wr_key), .wr_size_i(wr_size),
    .age_all_i(age_all), .touch_i(touch), .drop_i(drop),
    .ref_idx_i(ref_idx), .ref_rank_i(ref_rank), .clear_i(clr)
  );

  salru_ctrl #(.ENTRIES(ENTRIES), .IdxW(IdxW), .RankW(RankW)) u_ctrl (
    .clk_i, .rst_ni, .capacity_i(capacity_q),
    .in_valid_i, .in_ready_o, .command_i, .key_i, .seg_size_i,
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res),
    .rd_idx_o(rd_idx), .pf_idx_o(pf_idx), .rd_key_i(rd_key), .rd_size_i(rd_size),
    .rd_valid_i(rd_valid), .rd_rank_i(rd_rank),
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_key_o(wr_key), .wr_size_o(wr_size),
    .age_all_o(age_all), .touch_o(touch), .drop_o(drop), .ref_idx_o(ref_idx),
    .ref_rank_o(ref_rank), .clear_o(clr)
  );

  assign kind_o         = res.kind;
  assign evicted_key_o  = res.evicted_key;
  assign evicted_size_o = res.evicted_size;
  assign hit_o          = res.hit;
  assign rejected_o     = res.rejected;
  assign free_space_o   = res.free_space;
  assign last_o         = res.last;

endmodule

/* src/salru_checker.sv */
// salru_checker: port-level checks on the evictor top level
// depends on salru_pkg; bound to size_aware_lru_evictor_top
module salru_checker import salru_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic kind_o,
  input logic last_o,
  input logic hit_o,
  input logic rejected_o
);

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");

  // eviction reports are never final
  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !last_o) else $error("eviction marked last");

  // evictions carry no hit or reject
  a_evict_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !hit_o && !rejected_o) else $error("eviction flags");

  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  // result flags unchanged while stalled
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({kind_o, last_o, hit_o, rejected_o}))
    else $error("result changed while stalled");

endmodule

bind size_aware_lru_evictor_top salru_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .kind_o, .last_o, .hit_o, .rejected_o
);

/* tb/testbench.sv */
// testbench for the size-aware lru evictor: random and directed commands
// checked against a cycle-free model of the table; depends on salru_pkg and size_aware_lru_evictor_top
`timescale 1ns / 100ps
module testbench;
  import salru_pkg::*;

  localparam int unsigned Slots = 32;
  localparam int unsigned WatchLimit = 5000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       command_i = CMD_CLEAR;
  logic [KeyW-1:0]  key_i = '0;
  logic [SizeW-1:0] seg_size_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             kind_o;
  logic [KeyW-1:0]  evicted_key_o;
  logic [SizeW-1:0] evicted_size_o;
  logic             hit_o;
  logic             rejected_o;
  logic [SizeW-1:0] free_space_o;
  logic             last_o;

  size_aware_lru_evictor_top #(.ENTRIES(Slots)) dut (.*);

  // clock
  always #1 clk_i = ~clk_i;

  // model of the table
  logic [SizeW-1:0] mdl_cap = CapReset;
  logic [SizeW-1:0] mdl_free = CapReset;
  logic [KeyW-1:0]  mdl_key [Slots];
  logic [SizeW-1:0] mdl_size [Slots];
  bit               mdl_valid [Slots];
  int unsigned      mdl_rank [Slots];
  int unsigned      mdl_held = 0;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  bit          quiet = 1'b0;
  bit          hold_rx = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic void push_result(logic kind, logic [KeyW-1:0] ek,
                                      logic [SizeW-1:0] es, logic hit, logic rej,
                                      logic last);
    result_t r;
    r.kind = kind; r.evicted_key = ek; r.evicted_size = es; r.hit = hit;
    r.rejected = rej; r.free_space = mdl_free; r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_entry(int i);
    logic [SizeW:0] sum;
    for (int j = 0; j < Slots; j++)
      if (mdl_valid[j] && mdl_rank[j] > mdl_rank[i]) mdl_rank[j]--;
    mdl_valid[i] = 1'b0;
    mdl_rank[i] = 0;
    if (mdl_held > 0) mdl_held--;
    // returned bytes saturate
    sum = {1'b0, mdl_free} + {1'b0, mdl_size[i]};
    mdl_free = sum[SizeW] ? SizeMax : sum[SizeW-1:0];
  endfunction

  function automatic int lookup_key(logic [KeyW-1:0] k);
    for (int i = 0; i < Slots; i++)
      if (mdl_valid[i] && mdl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void predict_command(cmd_e cmd, logic [KeyW-1:0] k,
                                          logic [SizeW-1:0] sz);
    int v;
    int slot;
    logic [KeyW-1:0] ek;
    logic [SizeW-1:0] es;
    case (cmd)
      CMD_STORE: begin
        if (sz > mdl_cap) begin
          push_result(1'b0, '0, '0, 1'b0, 1'b1, 1'b1);
          return;
        end
        // evict least recent until bytes and a slot are available
        while (mdl_free < sz || mdl_held >= Slots) begin
          v = -1;
          for (int i = 0; i < Slots; i++)
            if (mdl_valid[i] && (v < 0 || mdl_rank[i] > mdl_rank[v])) v = i;
          if (v < 0) break;
          ek = mdl_key[v];
          es = mdl_size[v];
          drop_entry(v);
          push_result(1'b1, ek, es, 1'b0, 1'b0, 1'b0);
        end
        slot = -1;
        for (int i = Slots - 1; i >= 0; i--)
          if (!mdl_valid[i]) slot = i;
        if (mdl_free < sz || mdl_held >= Slots || slot < 0) begin
          push_result(1'b0, '0, '0, 1'b0, 1'b1, 1'b1);
          return;
        end
        for (int j = 0; j < Slots; j++)
          if (mdl_valid[j]) mdl_rank[j]++;
        mdl_valid[slot] = 1'b1;
        mdl_key[slot] = k;
        mdl_size[slot] = sz;
        mdl_rank[slot] = 0;
        mdl_held++;
        mdl_free = mdl_free - sz;
        push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      CMD_LOAD: begin
        v = lookup_key(k);
        if (v >= 0) begin
          for (int j = 0; j < Slots; j++)
            if (mdl_valid[j] && mdl_rank[j] < mdl_rank[v]) mdl_rank[j]++;
          mdl_rank[v] = 0;
        end
        push_result(1'b0, '0, '0, v >= 0, 1'b0, 1'b1);
      end
      CMD_REMOVE: begin
        v = lookup_key(k);
        if (v >= 0) drop_entry(v);
        push_result(1'b0, '0, '0, v >= 0, 1'b0, 1'b1);
      end
      default: begin
        for (int i = 0; i < Slots; i++) begin
          mdl_valid[i] = 1'b0;
          mdl_rank[i] = 0;
        end
        mdl_held = 0;
        mdl_free = mdl_cap;
        push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // send one item, predicting its results when it is accepted
  task automatic send_cmd(cmd_e cmd, logic [KeyW-1:0] k, logic [SizeW-1:0] sz);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    key_i <= k;
    seg_size_i <= sz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_command(cmd, k, sz);
  endtask

  // pause until every expected result has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [SizeW-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_cap = value;
  endtask

  // receiver: random stalls, with one long hold on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item, kind %0d", kind_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind !== kind_o || exp_r.evicted_key !== evicted_key_o ||
            exp_r.evicted_size !== evicted_size_o || exp_r.hit !== hit_o ||
            exp_r.rejected !== rejected_o || exp_r.free_space !== free_space_o ||
            exp_r.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d key %h sz %h h%0d r%0d free %h l%0d",
                     exp_r.kind, exp_r.evicted_key, exp_r.evicted_size, exp_r.hit,
                     exp_r.rejected, exp_r.free_space, exp_r.last,
                     "\n         got k%0d key %h sz %h h%0d r%0d free %h l%0d",
                     kind_o, evicted_key_o, evicted_size_o, hit_o, rejected_o,
                     free_space_o, last_o);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [SizeW-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SizeW-1:0];
  endfunction

  task automatic test_basic();
    send_cmd(CMD_STORE, 32'h0, 40'h0);
    send_cmd(CMD_STORE, 32'hFFFF_FFFF, 40'd1000);
    send_cmd(CMD_LOAD, 32'h0, rand40());
    send_cmd(CMD_LOAD, 32'h1234_5678, 40'h0);
    // duplicate key lands in a second slot
    send_cmd(CMD_STORE, 32'hFFFF_FFFF, 40'd24);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 40'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 40'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 40'h0);
    send_cmd(CMD_STORE, 32'h5, SizeMax);
    send_cmd(CMD_STORE, 32'h6, CapReset);
    send_cmd(CMD_CLEAR, 32'hA5A5_A5A5, SizeMax);
  endtask

  task automatic test_evictions();
    // slot pressure: two more stores than slots
    for (int i = 0; i < Slots + 2; i++) send_cmd(CMD_STORE, i, 40'd7);
    write_capacity(40'd1000);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_STORE, 32'd1, 40'd400);
    send_cmd(CMD_STORE, 32'd2, 40'd400);
    send_cmd(CMD_LOAD, 32'd1, '0);
    send_cmd(CMD_STORE, 32'd3, 40'd1000);
    // raised capacity leaves free space out of reach
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_STORE, 32'd4, 40'd600);
    write_capacity(40'd5000);
    send_cmd(CMD_STORE, 32'd5, 40'd3000);
    write_capacity(40'd0);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_STORE, 32'd6, 40'd0);
    send_cmd(CMD_STORE, 32'd7, 40'd1);
    write_capacity(SizeMax);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_STORE, 32'd8, SizeMax);
    send_cmd(CMD_REMOVE, 32'd8, '0);
  endtask

  task automatic random_phase(int unsigned count, logic [SizeW-1:0] cap);
    cmd_e cmd;
    logic [KeyW-1:0] k;
    logic [SizeW-1:0] sz;
    logic [SizeW:0] wide;
    int unsigned pick;
    write_capacity(cap);
    send_cmd(CMD_CLEAR, $urandom, rand40());
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 20) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      cmd = pick < 50 ? CMD_STORE : pick < 75 ? CMD_LOAD : pick < 97 ? CMD_REMOVE
          : CMD_CLEAR;
      k = $urandom_range(0, 9) < 8 ? $urandom_range(0, 23) : $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) sz = rand40();
      else if (pick < 3) begin
        wide = {1'b0, rand40()} % ({1'b0, cap} + 1'b1);
        sz = wide[SizeW-1:0];
      end
      else sz = rand40() % ((cap >> 4) + 1'b1);
      send_cmd(cmd, k, sz);
    end
    quiet = 1'b0;
  endtask

  task automatic test_pressure();
    hold_rx = 1'b1;
    for (int i = 0; i < 20; i++) send_cmd(CMD_STORE, $urandom_range(0, 40), 40'd3);
    drain();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_rank[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic();
    test_evictions();
    test_pressure();
    random_phase(60, CapReset);
    random_phase(60, 40'd4096);
    random_phase(50, SizeMax);
    random_phase(40, rand40());
    random_phase(20, 40'd64);
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* size_aware_lru_evictor_top.f */
src/salru_pkg.sv
src/salru_table.sv
src/salru_ctrl.sv
src/size_aware_lru_evictor_top.sv
src/salru_checker.sv
tb/testbench.sv
